[design/huffman_bitstream_decoder_defines.svh]
// Assertion macros shared by the decoder top level.
`ifndef HUFFMAN_BITSTREAM_DECODER_DEFINES_SVH
`define HUFFMAN_BITSTREAM_DECODER_DEFINES_SVH

// Same-cycle implication, sampled on clk_i, off while rst_ni is low.
`define HBD_ASSERT_IMPL(name, ante, cons, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk_i, off while rst_ni is low.
`define HBD_ASSERT_NEXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

[design/hbd_pkg.sv]
`default_nettype none

package hbd_pkg;

  localparam int BYTE_BITS = 8;
  localparam int NBIT_W    = 4;
  localparam int CODE_W    = 16;
  localparam int CLEN_W    = 5;
  localparam int SYMV_W    = 8;

  typedef enum logic [1:0] {
    CMD_LOAD  = 2'd0,
    CMD_BYTE  = 2'd1,
    CMD_CLEAR = 2'd2
  } cmd_e;

  typedef enum logic [1:0] {
    KIND_SYMBOL = 2'd0,
    KIND_END    = 2'd1,
    KIND_ERROR  = 2'd2
  } kind_e;

  typedef struct packed {
    logic [1:0]           command;
    logic [SYMV_W-1:0]    symbol_value;
    logic [CODE_W-1:0]    code_bits;
    logic [CLEN_W-1:0]    code_length;
    logic [BYTE_BITS-1:0] data_byte;
    logic                 last_byte;
    logic [2:0]           padding_bits;
  } in_item_t;

  typedef struct packed {
    logic [1:0]        result_kind;
    logic [SYMV_W-1:0] symbol;
    logic              last_result;
  } out_item_t;

  typedef struct packed {
    logic [1:0]        kind;
    logic [SYMV_W-1:0] sym;
  } res_t;

  typedef struct packed {
    logic [CODE_W-1:0] code;
    logic [CLEN_W-1:0] len;
  } entry_t;

  typedef struct packed {
    logic load_entry;
    logic clear_table;
    logic take_byte;
    logic shift_bit;
    logic scan_issue;
    logic res_capture;
    logic res_end;
    logic merge;
    logic push_last;
  } dp_cmd_t;

  typedef struct packed {
    logic hit;
    logic cmp_done;
    logic issue_more;
    logic bits_left;
    logic last_byte;
    logic res_vld;
    logic pend_vld;
    logic out_free;
  } dp_status_t;

endpackage

`default_nettype wire

[design/hbd_if.sv]
`default_nettype none

interface hbd_in_if import hbd_pkg::*; ();
  logic     valid;
  logic     ready;
  in_item_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface hbd_out_if import hbd_pkg::*; ();
  logic      valid;
  logic      ready;
  out_item_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

`default_nettype wire

[design/hbd_datapath.sv]
`default_nettype none

module hbd_datapath import hbd_pkg::*; #(
  parameter int NUM_SYMBOLS  = 256,
  parameter int MAX_CODE_LEN = 16
) (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire in_item_t   in_data_i,
  input  wire logic       out_ready_i,
  input  wire dp_cmd_t    cmd_i,
  output dp_status_t      status_o,
  output logic            out_valid_o,
  output out_item_t       out_data_o
);

  localparam int SYM_W  = $clog2(NUM_SYMBOLS);
  localparam int CNT_W  = $clog2(NUM_SYMBOLS + 1);
  localparam int LEN_W  = $clog2(MAX_CODE_LEN + 1);
  localparam int CMPC_W = (MAX_CODE_LEN > CODE_W) ? MAX_CODE_LEN : CODE_W;
  localparam int CMPL_W = (LEN_W > CLEN_W) ? LEN_W : CLEN_W;

  // code table
  entry_t                 entry_mem_q [NUM_SYMBOLS];
  logic [NUM_SYMBOLS-1:0] valid_q;
  entry_t                 rd_entry_q;
  logic                   rd_valid_q;

  logic [CODE_W-1:0]      load_mask;
  logic                   load_ok;
  logic [SYM_W-1:0]       load_idx;

  // scan pipeline
  logic [CNT_W-1:0]       scan_idx_q;
  logic [SYM_W-1:0]       rd_addr;
  logic [SYM_W-1:0]       cmp_idx_q;
  logic                   cmp_live_q;
  logic                   hit;
  logic                   at_max;

  // bit source and partial code
  logic [BYTE_BITS-1:0]   byte_q;
  logic                   last_q;
  logic [NBIT_W-1:0]      nbits_q;
  logic [NBIT_W-1:0]      bit_cnt_q;
  logic [MAX_CODE_LEN-1:0] partial_code_q;
  logic [LEN_W-1:0]       partial_len_q;
  logic [MAX_CODE_LEN:0]  partial_ext;

  // result staging
  res_t                   res_q;
  logic                   res_vld_q;
  res_t                   pend_q;
  logic                   pend_vld_q;
  out_item_t              out_q;
  logic                   out_vld_q;
  logic                   push_mid;
  logic                   push;

  always_comb begin
    for (int i = 0; i < CODE_W; i++) begin
      load_mask[i] = (CLEN_W'(i) < in_data_i.code_length);
    end
  end

  assign load_ok = ({1'b0, in_data_i.symbol_value} < (SYMV_W + 1)'(NUM_SYMBOLS)) &&
                   (in_data_i.code_length != '0) &&
                   ({1'b0, in_data_i.code_length} <= (CLEN_W + 1)'(MAX_CODE_LEN));
  assign load_idx = in_data_i.symbol_value[SYM_W-1:0];
  assign rd_addr  = scan_idx_q[SYM_W-1:0];

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_entry && load_ok) begin
      entry_mem_q[load_idx] <= '{code: in_data_i.code_bits & load_mask,
                                 len:  in_data_i.code_length};
    end
  end

  always_ff @(posedge clk_i) begin
    rd_entry_q <= entry_mem_q[rd_addr];
    cmp_idx_q  <= rd_addr;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q    <= '0;
      rd_valid_q <= 1'b0;
      cmp_live_q <= 1'b0;
      scan_idx_q <= '0;
    end else begin
      rd_valid_q <= valid_q[rd_addr];
      cmp_live_q <= cmd_i.scan_issue;
      if (cmd_i.clear_table) begin
        valid_q <= '0;
      end else if (cmd_i.load_entry && load_ok) begin
        valid_q[load_idx] <= 1'b1;
      end
      if (cmd_i.shift_bit) begin
        scan_idx_q <= '0;
      end else if (cmd_i.scan_issue) begin
        scan_idx_q <= scan_idx_q + CNT_W'(1);
      end
    end
  end

  assign hit = cmp_live_q && rd_valid_q &&
               (CMPL_W'(rd_entry_q.len) == CMPL_W'(partial_len_q)) &&
               (CMPC_W'(rd_entry_q.code) == CMPC_W'(partial_code_q));
  assign at_max      = (partial_len_q == LEN_W'(MAX_CODE_LEN));
  assign partial_ext = {partial_code_q, byte_q[BYTE_BITS-1]};

  always_ff @(posedge clk_i) begin
    if (cmd_i.take_byte) begin
      byte_q <= in_data_i.data_byte;
    end else if (cmd_i.shift_bit) begin
      byte_q <= byte_q << 1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      last_q         <= 1'b0;
      nbits_q        <= '0;
      bit_cnt_q      <= '0;
      partial_code_q <= '0;
      partial_len_q  <= '0;
    end else begin
      if (cmd_i.take_byte) begin
        last_q    <= in_data_i.last_byte;
        bit_cnt_q <= '0;
        // padding counts only on the final byte
        nbits_q   <= in_data_i.last_byte ?
                     NBIT_W'(BYTE_BITS) - {1'b0, in_data_i.padding_bits} :
                     NBIT_W'(BYTE_BITS);
      end else if (cmd_i.shift_bit) begin
        bit_cnt_q <= bit_cnt_q + NBIT_W'(1);
      end
      if (cmd_i.shift_bit) begin
        partial_code_q <= partial_ext[MAX_CODE_LEN-1:0];
        partial_len_q  <= partial_len_q + LEN_W'(1);
      end else if (cmd_i.merge && res_vld_q) begin
        partial_code_q <= '0;
        partial_len_q  <= '0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.res_capture) begin
      res_q.kind <= hit ? KIND_SYMBOL : KIND_ERROR;
      res_q.sym  <= hit ? SYMV_W'(cmp_idx_q) : '0;
    end else if (cmd_i.res_end) begin
      res_q.kind <= (partial_len_q != '0) ? KIND_ERROR : KIND_END;
      res_q.sym  <= '0;
    end
    if (cmd_i.merge && res_vld_q) begin
      pend_q <= res_q;
    end
  end

  assign push_mid = cmd_i.merge && res_vld_q && pend_vld_q;
  assign push     = push_mid || cmd_i.push_last;

  always_ff @(posedge clk_i) begin
    if (push) begin
      out_q <= '{result_kind: pend_q.kind, symbol: pend_q.sym,
                 last_result: cmd_i.push_last};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_vld_q  <= 1'b0;
      pend_vld_q <= 1'b0;
      out_vld_q  <= 1'b0;
    end else begin
      if (cmd_i.res_capture) begin
        res_vld_q <= hit || at_max;
      end else if (cmd_i.res_end) begin
        res_vld_q <= 1'b1;
      end else if (cmd_i.merge) begin
        res_vld_q <= 1'b0;
      end
      // hold the newest result back until the next one shows whether it is the final one
      if (cmd_i.merge && res_vld_q) begin
        pend_vld_q <= 1'b1;
      end else if (cmd_i.push_last) begin
        pend_vld_q <= 1'b0;
      end
      if (push) begin
        out_vld_q <= 1'b1;
      end else if (out_ready_i) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  assign status_o.hit        = hit;
  assign status_o.cmp_done   = cmp_live_q && (cmp_idx_q == SYM_W'(NUM_SYMBOLS - 1));
  assign status_o.issue_more = (scan_idx_q < CNT_W'(NUM_SYMBOLS));
  assign status_o.bits_left  = (bit_cnt_q != nbits_q);
  assign status_o.last_byte  = last_q;
  assign status_o.res_vld    = res_vld_q;
  assign status_o.pend_vld   = pend_vld_q;
  assign status_o.out_free   = !out_vld_q || out_ready_i;

  assign out_valid_o = out_vld_q;
  assign out_data_o  = out_q;

endmodule

`default_nettype wire

[design/hbd_ctrl.sv]
`default_nettype none

module hbd_ctrl import hbd_pkg::*; (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       in_valid_i,
  input  wire logic [1:0] in_command_i,
  input  wire dp_status_t status_i,
  output logic            in_ready_o,
  output dp_cmd_t         cmd_o
);

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_SHIFT = 3'd1;
  localparam logic [2:0] ST_SCAN  = 3'd2;
  localparam logic [2:0] ST_MERGE = 3'd3;
  localparam logic [2:0] ST_ENDR  = 3'd4;
  localparam logic [2:0] ST_FLUSH = 3'd5;

  logic [2:0] state_q, state_d;
  logic       ended_q, ended_d;

  assign in_ready_o = (state_q == ST_IDLE);

  always_comb begin
    state_d = state_q;
    ended_d = ended_q;
    cmd_o   = '0;
    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          unique case (in_command_i)
            CMD_LOAD:  cmd_o.load_entry  = 1'b1;
            CMD_CLEAR: cmd_o.clear_table = 1'b1;
            CMD_BYTE: begin
              cmd_o.take_byte = 1'b1;
              ended_d         = 1'b0;
              state_d         = ST_SHIFT;
            end
            default: ;
          endcase
        end
      end
      ST_SHIFT: begin
        cmd_o.shift_bit = 1'b1;
        state_d         = ST_SCAN;
      end
      ST_SCAN: begin
        // stop issuing reads once the lowest matching entry is seen
        cmd_o.scan_issue = !status_i.hit && status_i.issue_more;
        if (status_i.hit || status_i.cmp_done) begin
          cmd_o.res_capture = 1'b1;
          state_d           = ST_MERGE;
        end
      end
      ST_MERGE: begin
        if (!(status_i.res_vld && status_i.pend_vld && !status_i.out_free)) begin
          cmd_o.merge = 1'b1;
          priority if (status_i.bits_left) begin
            state_d = ST_SHIFT;
          end else if (status_i.last_byte && !ended_q) begin
            state_d = ST_ENDR;
          end else begin
            state_d = ST_FLUSH;
          end
        end
      end
      ST_ENDR: begin
        cmd_o.res_end = 1'b1;
        ended_d       = 1'b1;
        state_d       = ST_MERGE;
      end
      ST_FLUSH: begin
        priority if (!status_i.pend_vld) begin
          state_d = ST_IDLE;
        end else if (status_i.out_free) begin
          cmd_o.push_last = 1'b1;
          state_d         = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      ended_q <= 1'b0;
    end else begin
      state_q <= state_d;
      ended_q <= ended_d;
    end
  end

endmodule

`default_nettype wire

[design/huffman_bitstream_decoder.sv]
// Huffman bitstream decoder.
// Input channel in_i carries one word per command: load a code table entry,
// clear the whole table, or feed one compressed byte (MSB first; the final
// byte drops padding_bits from its low end). Output channel out_o carries
// decoded symbols, a stream-end word or an error word; last_result marks the
// final word caused by one input word.
// Load and clear act in the idle state, and the next word is taken right after.
// A byte takes, per bit, a shift step, a table scan that stops at the lowest
// matching symbol (or runs through every entry when nothing matches) and a
// merge step; a final byte then adds a stream-end step and a merge, and every
// byte ends with a flush before the next word is taken.
// The scan reads the code table memory one entry per cycle, so its depth sets
// the rate.
// Reset clears all valid bits at once (no clearing pass), empties the
// partial code and drops any pending output word.
// When out_o stalls, the finished word waits in the output register and
// decoding of the next result goes on; the block holds only when a new result
// meets a pending one behind it, or when a pending word must be flushed.
`default_nettype none
`include "huffman_bitstream_decoder_defines.svh"

module huffman_bitstream_decoder import hbd_pkg::*; #(
  parameter int NUM_SYMBOLS  = 256,
  parameter int MAX_CODE_LEN = 16
) (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  hbd_in_if.sink    in_i,
  hbd_out_if.source out_o
);

  dp_cmd_t    cmd;
  dp_status_t st;
  logic       in_ready;

  hbd_ctrl u_ctrl (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_i.valid),
    .in_command_i (in_i.data.command),
    .status_i     (st),
    .in_ready_o   (in_ready),
    .cmd_o        (cmd)
  );

  hbd_datapath #(
    .NUM_SYMBOLS  (NUM_SYMBOLS),
    .MAX_CODE_LEN (MAX_CODE_LEN)
  ) u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_data_i   (in_i.data),
    .out_ready_i (out_o.ready),
    .cmd_i       (cmd),
    .status_o    (st),
    .out_valid_o (out_o.valid),
    .out_data_o  (out_o.data)
  );

  assign in_i.ready = in_ready;

  `HBD_ASSERT_IMPL(a_push_has_room, (cmd.push_last || (cmd.merge && st.res_vld && st.pend_vld)), st.out_free, "result word pushed over an unconsumed word")
  `HBD_ASSERT_IMPL(a_idle_is_drained, in_ready, (!st.pend_vld && !st.res_vld), "input taken while a result is still held")
  `HBD_ASSERT_IMPL(a_hit_follows_read, st.hit, $past(cmd.scan_issue), "table match without a read issued")
  `HBD_ASSERT_NEXT(a_byte_starts_shift, (in_ready && in_i.valid && (in_i.data.command == CMD_BYTE)), cmd.shift_bit, "byte taken without shifting its first bit")

endmodule

`default_nettype wire

[tb/huffman_bitstream_decoder_test.sv]
`default_nettype none

module huffman_bitstream_decoder_test;
  import hbd_pkg::*;

  localparam int NUM_SYMBOLS = 256;
  localparam int MAX_LEN = 16;
  localparam logic [1:0] CMD_UNKNOWN = 2'd3;
  localparam int USE_PREDICTOR = -1;
  localparam int STALL_LIMIT = 20000;
  localparam int TAIL_CYCLES = 8 * (NUM_SYMBOLS + 3) + 100;
  localparam int RANDOM_WORDS = 170;
  localparam int QUIET_TAIL = 40;

  logic clk_i;
  logic rst_ni;

  hbd_in_if  in_if ();
  hbd_out_if out_if ();

  huffman_bitstream_decoder #(
    .NUM_SYMBOLS  (NUM_SYMBOLS),
    .MAX_CODE_LEN (MAX_LEN)
  ) dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_if),
    .out_o  (out_if)
  );

  // Mirror of the code table and the partial code.
  logic [CODE_W-1:0] code_tbl [NUM_SYMBOLS];
  logic [CLEN_W-1:0] len_tbl [NUM_SYMBOLS];
  bit                valid_tbl [NUM_SYMBOLS];
  logic [CODE_W-1:0] part_code = '0;
  int                part_len = 0;

  out_item_t pending_results [$];
  out_item_t step_results [$];

  typedef struct {
    in_item_t word;
    int       n_typed;
    kind_e    kind0;
    kind_e    kind1;
  } plan_row_t;

  plan_row_t plan [$];

  int failures = 0;
  int reported = 0;
  int words_sent = 0;
  int useful_words = 0;
  int streams = 0;
  int symbols_seen = 0;
  int ends_seen = 0;
  int errors_seen = 0;
  int quiet_cycles = 0;
  bit idle_on = 1'b1;

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  function automatic void note_failure(string msg);
    failures++;
    if (reported < 10) begin
      reported++;
      $display("ERROR: %s", msg);
    end
  endfunction

  function automatic void push_result(logic [1:0] kind, logic [SYMV_W-1:0] sym);
    out_item_t r;
    r.result_kind = kind;
    r.symbol = sym;
    r.last_result = 1'b0;
    step_results = {step_results, r};
  endfunction

  // Compute the results one accepted word causes and advance the mirror.
  function automatic void decode_word(in_item_t w);
    int nbits;
    int hit;
    logic [31:0] mask;
    step_results.delete();
    case (w.command)
      CMD_LOAD: begin
        if (w.code_length >= 1 && w.code_length <= MAX_LEN) begin
          mask = (32'd1 << w.code_length) - 32'd1;
          code_tbl[w.symbol_value] = w.code_bits & mask[CODE_W-1:0];
          len_tbl[w.symbol_value] = w.code_length;
          valid_tbl[w.symbol_value] = 1'b1;
        end
      end
      CMD_CLEAR: begin
        foreach (valid_tbl[s]) valid_tbl[s] = 1'b0;
      end
      CMD_BYTE: begin
        nbits = w.last_byte ? BYTE_BITS - int'(w.padding_bits) : BYTE_BITS;
        for (int k = 0; k < nbits; k++) begin
          part_code = {part_code[CODE_W-2:0], w.data_byte[7-k]};
          part_len++;
          hit = -1;
          // lowest symbol wins among duplicate codes
          for (int s = 0; s < NUM_SYMBOLS; s++) begin
            if (valid_tbl[s] && int'(len_tbl[s]) == part_len && code_tbl[s] == part_code) begin
              hit = s;
              break;
            end
          end
          if (hit >= 0) begin
            push_result(KIND_SYMBOL, SYMV_W'(hit));
            part_code = '0;
            part_len = 0;
          end else if (part_len >= MAX_LEN) begin
            push_result(KIND_ERROR, '0);
            part_code = '0;
            part_len = 0;
          end
        end
        if (w.last_byte) begin
          push_result(part_len != 0 ? KIND_ERROR : KIND_END, '0);
          part_code = '0;
          part_len = 0;
        end
      end
      default: ;
    endcase
    if (step_results.size() > 0) step_results[step_results.size()-1].last_result = 1'b1;
  endfunction

  function automatic in_item_t make_word(logic [1:0] cmd);
    in_item_t w;
    logic [31:0] r0;
    logic [31:0] r1;
    r0 = $urandom;
    r1 = $urandom;
    w.command = cmd;
    w.symbol_value = r0[7:0];
    w.code_bits = r0[23:8];
    w.code_length = r1[4:0];
    w.data_byte = r1[12:5];
    w.last_byte = r1[13];
    w.padding_bits = r1[16:14];
    return w;
  endfunction

  function automatic in_item_t load_word(logic [7:0] sym, logic [15:0] bits, logic [4:0] len);
    in_item_t w;
    w = make_word(CMD_LOAD);
    w.symbol_value = sym;
    w.code_bits = bits;
    w.code_length = len;
    return w;
  endfunction

  function automatic in_item_t byte_word(logic [7:0] data, logic last, logic [2:0] pad);
    in_item_t w;
    w = make_word(CMD_BYTE);
    w.data_byte = data;
    w.last_byte = last;
    w.padding_bits = pad;
    return w;
  endfunction

  function automatic void add_row(in_item_t w, int n_typed, kind_e k0 = KIND_SYMBOL,
                                  kind_e k1 = KIND_SYMBOL);
    plan_row_t row;
    row.word = w;
    row.n_typed = n_typed;
    row.kind0 = k0;
    row.kind1 = k1;
    plan = {plan, row};
  endfunction

  // Offer one word, hold it until taken, then predict from it.
  task automatic send_word(in_item_t w, bit typed);
    int gap;
    if (idle_on && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 8);
      in_if.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_if.valid <= 1'b1;
    in_if.data <= w;
    do @(posedge clk_i); while (in_if.ready !== 1'b1);
    decode_word(w);
    if (!typed) foreach (step_results[i]) pending_results = {pending_results, step_results[i]};
    words_sent++;
    if (!(w.command == CMD_UNKNOWN ||
          (w.command == CMD_LOAD && (w.code_length == 0 || w.code_length > MAX_LEN))))
      useful_words++;
  endtask

  task automatic drain();
    in_if.valid <= 1'b0;
    do @(posedge clk_i); while (pending_results.size() != 0);
  endtask

  // Random prefix code, loaded into a cleared table, then a stream encoded with it.
  task automatic play_stream();
    int n_leaves;
    int n_codes;
    int idx;
    int drop;
    int pick;
    int take;
    int trim;
    int c;
    int l;
    bit skew;
    bit last;
    int leaf_code [$];
    int leaf_len [$];
    int leaf_sym [$];
    bit used [NUM_SYMBOLS];
    bit stream [$];
    logic [7:0] b;
    logic [31:0] r;
    logic [31:0] bits_v;

    n_leaves = $urandom_range(2, 17);
    skew = ($urandom_range(0, 2) == 0);
    leaf_code = {leaf_code, int'(0)};
    leaf_len = {leaf_len, int'(0)};
    // a skewed tree keeps splitting the newest leaf, which reaches the longest codes
    while (leaf_code.size() < n_leaves) begin
      idx = skew ? leaf_code.size() - 1 : $urandom_range(0, leaf_code.size() - 1);
      if (leaf_len[idx] < MAX_LEN) begin
        c = leaf_code[idx];
        l = leaf_len[idx];
        leaf_code[idx] = c << 1;
        leaf_len[idx] = l + 1;
        leaf_code = {leaf_code, int'((c << 1) | 1)};
        leaf_len = {leaf_len, int'(l + 1)};
      end
    end
    foreach (leaf_code[i]) begin
      do
        pick = $urandom_range(0, 1) ? $urandom_range(0, 31) : $urandom_range(0, NUM_SYMBOLS - 1);
      while (used[pick]);
      used[pick] = 1'b1;
      leaf_sym = {leaf_sym, pick};
    end
    // leave one code out now and then so the table has a hole
    drop = ($urandom_range(0, 7) == 0) ? $urandom_range(0, n_leaves - 1) : -1;

    send_word(make_word(CMD_CLEAR), 1'b0);
    streams++;
    foreach (leaf_code[i]) begin
      if (i != drop) begin
        r = $urandom;
        bits_v = leaf_code[i] | (r << leaf_len[i]);
        send_word(load_word(8'(leaf_sym[i]), bits_v[15:0], 5'(leaf_len[i])), 1'b0);
        if ($urandom_range(0, 9) == 0) send_word(make_word(CMD_UNKNOWN), 1'b0);
      end
    end

    n_codes = $urandom_range(1, 16);
    repeat (n_codes) begin
      do pick = $urandom_range(0, n_leaves - 1); while (pick == drop);
      for (int j = leaf_len[pick] - 1; j >= 0; j--) stream = {stream, leaf_code[pick][j]};
    end
    // cut the tail off some streams to leave a partial code behind
    if ($urandom_range(0, 7) == 0) begin
      trim = $urandom_range(1, 3);
      while (trim > 0 && stream.size() > 1) begin
        stream = stream[0:$-1];
        trim--;
      end
    end

    while (stream.size() > 0) begin
      r = $urandom;
      b = r[7:0];
      take = stream.size() < 8 ? stream.size() : 8;
      for (int j = 0; j < take; j++) b[7-j] = stream.pop_front();
      last = (stream.size() == 0);
      send_word(byte_word(b, last, last ? 3'(8 - take) : r[10:8]), 1'b0);
    end
  endtask

  task automatic play_noise();
    int sel;
    repeat ($urandom_range(1, 6)) begin
      sel = $urandom_range(0, 9);
      if (sel < 5)      send_word(make_word(CMD_BYTE), 1'b0);
      else if (sel < 8) send_word(make_word(CMD_LOAD), 1'b0);
      else if (sel < 9) send_word(make_word(CMD_UNKNOWN), 1'b0);
      else              send_word(make_word(CMD_CLEAR), 1'b0);
    end
  endtask

  always @(posedge clk_i) begin
    if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
  end

  initial begin
    do @(posedge clk_i); while (quiet_cycles < STALL_LIMIT);
    $display("Timeout: no word moved for %0d cycles", STALL_LIMIT);
    $display("Verification failed");
    $finish;
  end

  // Result side: check each accepted word, then pick the next ready value.
  initial begin
    int stall_left;
    out_item_t got;
    out_item_t want;
    stall_left = 0;
    out_if.ready = 1'b0;
    forever begin
      @(posedge clk_i);
      if (rst_ni && out_if.valid && out_if.ready) begin
        got = out_if.data;
        if (got.result_kind == KIND_SYMBOL) symbols_seen++;
        else if (got.result_kind == KIND_END) ends_seen++;
        else errors_seen++;
        if (pending_results.size() == 0) begin
          note_failure($sformatf("unexpected word kind=%0d sym=%0d last=%0d",
                                 got.result_kind, got.symbol, got.last_result));
        end else begin
          want = pending_results.pop_front();
          if (got.result_kind !== want.result_kind || got.symbol !== want.symbol ||
              got.last_result !== want.last_result)
            note_failure($sformatf("expected kind=%0d sym=%0d last=%0d, got kind=%0d sym=%0d last=%0d",
                                   want.result_kind, want.symbol, want.last_result,
                                   got.result_kind, got.symbol, got.last_result));
        end
      end
      if (stall_left > 0) begin
        stall_left--;
        out_if.ready <= 1'b0;
      end else if (idle_on && $urandom_range(0, 7) == 0) begin
        stall_left = $urandom_range(0, 7);
        out_if.ready <= 1'b0;
      end else begin
        out_if.ready <= 1'b1;
      end
    end
  end

  initial begin
    out_item_t r;
    int random_start;
    rst_ni = 1'b0;
    in_if.valid = 1'b0;
    in_if.data = '0;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    add_row(byte_word(8'h00, 1'b1, 3'd0), 1, KIND_ERROR);   // empty table, eight bits left over
    add_row(byte_word(8'hA5, 1'b1, 3'd7), 1, KIND_ERROR);   // one bit survives padding
    add_row(make_word(CMD_UNKNOWN), 0);
    add_row(make_word(CMD_CLEAR), 0);
    add_row(load_word(8'd0, 16'hFFFE, 5'd1), 0);            // masks down to a single 0
    add_row(load_word(8'd255, 16'hFFFF, 5'd16), 0);
    add_row(load_word(8'd7, 16'h0000, 5'd0), 0);            // bad lengths are dropped
    add_row(load_word(8'd7, 16'h0003, 5'd17), 0);
    add_row(load_word(8'd8, 16'h0001, 5'd31), 0);
    add_row(byte_word(8'h00, 1'b1, 3'd0), USE_PREDICTOR);   // eight symbols and the end
    add_row(byte_word(8'hFF, 1'b0, 3'd7), 0);               // padding ignored off the last word
    add_row(byte_word(8'hFF, 1'b1, 3'd0), USE_PREDICTOR);   // completes the 16-bit code
    add_row(load_word(8'd1, 16'h0001, 5'd1), 0);
    add_row(load_word(8'd9, 16'h0000, 5'd1), 0);            // same code as symbol 0
    add_row(byte_word(8'h7F, 1'b1, 3'd4), USE_PREDICTOR);
    add_row(make_word(CMD_CLEAR), 0);
    add_row(byte_word(8'h00, 1'b0, 3'd0), 0);
    add_row(byte_word(8'h00, 1'b1, 3'd0), 2, KIND_ERROR, KIND_END); // runs past the length limit
    add_row(load_word(8'd200, 16'h0005, 5'd3), 0);
    add_row(load_word(8'd100, 16'h0000, 5'd1), 0);
    add_row(byte_word(8'hA8, 1'b1, 3'd3), USE_PREDICTOR);

    foreach (plan[i]) begin
      send_word(plan[i].word, plan[i].n_typed != USE_PREDICTOR);
      for (int j = 0; j < plan[i].n_typed; j++) begin
        r.result_kind = (j == 0) ? plan[i].kind0 : plan[i].kind1;
        r.symbol = '0;
        r.last_result = (j == plan[i].n_typed - 1);
        pending_results = {pending_results, r};
      end
    end
    drain();

    random_start = useful_words;
    while (useful_words - random_start < RANDOM_WORDS) begin
      idle_on = (useful_words - random_start < RANDOM_WORDS - QUIET_TAIL) &&
                ($urandom_range(0, 4) != 0);
      if ($urandom_range(0, 9) < 7) play_stream();
      else play_noise();
      if ($urandom_range(0, 9) == 0) drain();
    end
    idle_on = 1'b0;
    in_if.valid <= 1'b0;

    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (TAIL_CYCLES) @(posedge clk_i);
    failures += pending_results.size();

    $display("Sent %0d words (%0d acted on) over %0d well-formed streams plus noise.",
             words_sent, useful_words, streams);
    $display("Checked %0d symbols, %0d stream ends, %0d error words; %0d failures.",
             symbols_seen, ends_seen, errors_seen, failures);
    if (failures == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

`default_nettype wire
